>>> hdl/asp_pkg.sv
// ----------------------------------------------------------------------------
// asp_pkg
// Shared types, constants and the SGR staging function for the ANSI SGR /
// UTF-8 byte parser.
// ----------------------------------------------------------------------------
package asp_pkg;

	localparam int PARAM_SLOTS = 8;
	localparam int PARAM_BITS  = 16;
	localparam int PIDX_W      = (PARAM_SLOTS > 1) ? $clog2(PARAM_SLOTS) : 1;

	localparam int CP_W        = 21;
	localparam int COLOR_W     = 5;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [COLOR_W-1:0] COLOR_DEFAULT = 5'd16;

	localparam logic [CP_W-1:0] CP_BAD  = 21'h00FFFD;
	localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;

	localparam logic [7:0] BYTE_ESC    = 8'h1B;
	localparam logic [7:0] BYTE_LBRACK = 8'h5B;
	localparam logic [7:0] BYTE_SEMI   = 8'h3B;
	localparam logic [7:0] BYTE_M      = 8'h6D;
	localparam logic [7:0] BYTE_ZERO   = 8'h30;
	localparam logic [7:0] BYTE_NINE   = 8'h39;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_DIGIT,
		CLS_SEMI,
		CLS_LBRACK,
		CLS_FINAL_M,
		CLS_ESC
	} asp_cls_t;

	// One classified word travelling from front to back
	typedef struct packed {
		logic [7:0] data;
		asp_cls_t   cls;
	} asp_word_t;

	typedef struct packed {
		logic [COLOR_W-1:0] fg;
		logic [COLOR_W-1:0] bg;
	} asp_color_t;

	function automatic asp_color_t sgr_stage(input logic [PARAM_BITS-1:0] code,
			input asp_color_t cur);
		asp_color_t res;
		res = cur;
		if (code == PARAM_BITS'(0)) begin
			res.fg = COLOR_DEFAULT;
			res.bg = COLOR_DEFAULT;
		end else if (code >= PARAM_BITS'(30) && code <= PARAM_BITS'(37)) begin
			res.fg = COLOR_W'(code - PARAM_BITS'(30));
		end else if (code >= PARAM_BITS'(40) && code <= PARAM_BITS'(47)) begin
			res.bg = COLOR_W'(code - PARAM_BITS'(40));
		end else if (code >= PARAM_BITS'(90) && code <= PARAM_BITS'(97)) begin
			res.fg = COLOR_W'(code - PARAM_BITS'(82));
		end else if (code >= PARAM_BITS'(100) && code <= PARAM_BITS'(107)) begin
			res.bg = COLOR_W'(code - PARAM_BITS'(92));
		end
		return res;
	endfunction

endpackage

>>> hdl/asp_front.sv
// ----------------------------------------------------------------------------
// asp_front
// Input stage: accepts one byte per cycle while in_stall is low, classifies it
// and hands the classified word to the queue.
// ----------------------------------------------------------------------------
module asp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        in_byte,
	input  logic              q_full,
	output logic              push_valid,
	output asp_pkg::asp_word_t push_word
);
	import asp_pkg::*;

	logic      valid_s1;
	asp_word_t word_s1;

	function automatic asp_cls_t classify(input logic [7:0] b);
		asp_cls_t c;
		c = CLS_OTHER;
		if (b >= BYTE_ZERO && b <= BYTE_NINE) begin
			c = CLS_DIGIT;
		end else if (b == BYTE_SEMI) begin
			c = CLS_SEMI;
		end else if (b == BYTE_LBRACK) begin
			c = CLS_LBRACK;
		end else if (b == BYTE_M) begin
			c = CLS_FINAL_M;
		end else if (b == BYTE_ESC) begin
			c = CLS_ESC;
		end
		return c;
	endfunction

	// hold the staged word while the queue is full
	assign in_stall   = valid_s1 && q_full;
	assign push_valid = valid_s1 && !q_full;
	assign push_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1.data <= in_byte;
			word_s1.cls  <= classify(in_byte);
		end
	end

endmodule

>>> hdl/asp_queue.sv
// ----------------------------------------------------------------------------
// asp_queue
// Short FIFO of classified words between the front and back stages.
// ----------------------------------------------------------------------------
module asp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	input  asp_pkg::asp_word_t push_word,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output asp_pkg::asp_word_t head_word
);
	import asp_pkg::*;

	asp_word_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_pop;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_word  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(push_valid) - (QPTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> !full)
		else $error("queue written while full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !do_pop) |=> count_q == $past(count_q) + (QPTR_W+1)'(1))
		else $error("queue count lost a write");

endmodule

>>> hdl/asp_back.sv
// ----------------------------------------------------------------------------
// asp_back
// Execution stage: escape/CSI parser, SGR colour staging, UTF-8 decoder and
// the output register.
// ----------------------------------------------------------------------------
module asp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  asp_pkg::asp_word_t          head_word,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [asp_pkg::CP_W-1:0]    codepoint,
	output logic [asp_pkg::COLOR_W-1:0] glyph_fg,
	output logic [asp_pkg::COLOR_W-1:0] glyph_bg
);
	import asp_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_ESC    = 2'd1,
		MODE_CSI    = 2'd2
	} mode_t;

	mode_t                  mode_q, mode_d;
	logic [PARAM_BITS-1:0]  param_q, param_d;
	logic [PIDX_W-1:0]      pidx_q, pidx_d;
	logic [CP_W-1:0]        accum_q, accum_d;
	logic [1:0]             rem_q, rem_d;
	asp_color_t             now_q, now_d;
	asp_color_t             pend_q, pend_d;

	logic                   out_valid_q;
	logic [CP_W-1:0]        cp_q;
	asp_color_t             color_q;

	logic                   out_free;
	logic [7:0]             b;
	logic [CP_W-1:0]        cp_d;
	logic [CP_W-1:0]        acc_shift;
	logic [PARAM_BITS+3:0]  prod;
	asp_color_t             staged;
	logic                   emit;

	assign out_free  = !out_valid_q || !out_stall;
	assign pop       = head_valid && out_free;
	assign b         = head_word.data;
	assign acc_shift = {accum_q[CP_W-7:0], b[5:0]};
	assign prod      = ({4'b0, param_q} << 3) + ({4'b0, param_q} << 1)
		+ (PARAM_BITS+4)'(b[3:0]);
	assign staged    = sgr_stage(param_q, pend_q);
	assign emit      = (cp_d != '0);

	always_comb begin
		mode_d  = mode_q;
		param_d = param_q;
		pidx_d  = pidx_q;
		accum_d = accum_q;
		rem_d   = rem_q;
		now_d   = now_q;
		pend_d  = pend_q;
		cp_d    = '0;
		unique case (mode_q)
			MODE_ESC: begin
				if (head_word.cls == CLS_LBRACK) begin
					mode_d  = MODE_CSI;
					param_d = '0;
					pidx_d  = '0;
					pend_d  = now_q;
				end else begin
					mode_d = MODE_NORMAL;
				end
			end
			MODE_CSI: begin
				unique case (head_word.cls)
					CLS_DIGIT: begin
						// saturate at the all-ones parameter value
						if (prod > {4'b0, {PARAM_BITS{1'b1}}}) begin
							param_d = '1;
						end else begin
							param_d = prod[PARAM_BITS-1:0];
						end
					end
					CLS_SEMI: begin
						// ignore when the last slot is open
						if (pidx_q < PIDX_W'(PARAM_SLOTS - 1)) begin
							pend_d  = staged;
							pidx_d  = pidx_q + PIDX_W'(1);
							param_d = '0;
						end
					end
					default: begin
						if (head_word.cls == CLS_FINAL_M) begin
							now_d  = staged;
							pend_d = staged;
						end else begin
							pend_d = now_q;
						end
						param_d = '0;
						pidx_d  = '0;
						mode_d  = MODE_NORMAL;
					end
				endcase
			end
			default: begin
				mode_d = MODE_NORMAL;
				if (head_word.cls == CLS_ESC) begin
					mode_d  = MODE_ESC;
					accum_d = '0;
					rem_d   = '0;
				end else if (rem_q == 2'd0) begin
					if (!b[7]) begin
						cp_d = CP_W'(b);
					end else if (b[7:5] == 3'b110) begin
						accum_d = CP_W'(b[4:0]);
						rem_d   = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						accum_d = CP_W'(b[3:0]);
						rem_d   = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						accum_d = CP_W'(b[2:0]);
						rem_d   = 2'd3;
					end else begin
						cp_d = CP_BAD;
					end
				end else if (b[7:6] != 2'b10) begin
					// drop the partial sequence and consume this word
					accum_d = '0;
					rem_d   = '0;
					cp_d    = CP_BAD;
				end else begin
					rem_d = rem_q - 2'd1;
					if (rem_q == 2'd1) begin
						accum_d = '0;
						if (acc_shift > CP_MAX
								|| (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
							cp_d = CP_BAD;
						end else begin
							cp_d = acc_shift;
						end
					end else begin
						accum_d = acc_shift;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			param_q     <= '0;
			pidx_q      <= '0;
			accum_q     <= '0;
			rem_q       <= '0;
			now_q       <= '{fg: COLOR_DEFAULT, bg: COLOR_DEFAULT};
			pend_q      <= '{fg: COLOR_DEFAULT, bg: COLOR_DEFAULT};
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q  <= mode_d;
				param_q <= param_d;
				pidx_q  <= pidx_d;
				accum_q <= accum_d;
				rem_q   <= rem_d;
				now_q   <= now_d;
				pend_q  <= pend_d;
			end
			if (out_free) begin
				out_valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			cp_q    <= cp_d;
			color_q <= now_q;
		end
	end

	assign out_valid = out_valid_q;
	assign codepoint = cp_q;
	assign glyph_fg  = color_q.fg;
	assign glyph_bg  = color_q.bg;

	a_no_pop_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !pop)
		else $error("word consumed while result held");

	a_utf8_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != 2'd0) |-> (mode_q == MODE_NORMAL))
		else $error("partial UTF-8 sequence outside normal mode");

	a_csi_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q != MODE_CSI) |-> (pidx_q == '0 && param_q == '0 && pend_q == now_q))
		else $error("CSI state left over outside a sequence");

endmodule

>>> hdl/ansi_sgr_utf8_byte_parser.sv
// ----------------------------------------------------------------------------
// ansi_sgr_utf8_byte_parser
// Terminal byte parser: strips ANSI CSI sequences, applies SGR colours and
// decodes UTF-8 into codepoints tagged with foreground and background codes.
//
// Input channel: in_valid / in_stall / in_byte, one terminal byte per word.
// Output channel: out_valid / out_stall with codepoint, glyph_fg, glyph_bg.
// A byte yields zero or one output word; escape bytes, partial UTF-8
// sequences and NUL yield none.
// Throughput: one byte per cycle while in_stall is low. After the edge that
// accepts the byte, it is written to the queue, then to the output register.
// A 4-word queue between the classifier and the parser lets the input keep
// flowing while the output is stalled; when the queue fills, in_stall rises
// and holds until the output drains.
// Reset: asynchronous, active low; the parser returns to normal mode, colours
// go to the theme default (16) and all queued and pending words are dropped.
// ----------------------------------------------------------------------------
module ansi_sgr_utf8_byte_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  in_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [asp_pkg::CP_W-1:0]    codepoint,
	output logic [asp_pkg::COLOR_W-1:0] glyph_fg,
	output logic [asp_pkg::COLOR_W-1:0] glyph_bg
);
	import asp_pkg::*;

	logic      push_valid;
	asp_word_t push_word;
	logic      q_full;
	logic      pop;
	logic      head_valid;
	asp_word_t head_word;

	asp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.q_full     (q_full),
		.push_valid (push_valid),
		.push_word  (push_word)
	);

	asp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_word  (push_word),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word)
	);

	asp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_word  (head_word),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.codepoint  (codepoint),
		.glyph_fg   (glyph_fg),
		.glyph_bg   (glyph_bg)
	);

endmodule
